### design/asv_pkg.sv
// Shared constants and types for the ascending value sorter.
package asv_pkg;

   // Number of sorting cells, which is the list capacity.
   localparam int MAX_COUNT = 32;
   localparam int VALUE_W   = 32;
   // Wide enough to hold MAX_COUNT itself.
   localparam int CNT_W     = $clog2(MAX_COUNT + 1);

   // A value with its presence bit, as it moves between neighboring cells.
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } link_type;

endpackage

### design/asv_cell.sv
// One cell of the sorting chain: keeps the smaller value and passes the larger one on.
module asv_cell
   import asv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift,
   input  link_type ins_link,
   input  link_type right_link,
   output link_type pass_link,
   output link_type hold_link
);

   logic                      full_ff, full_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      pass_valid_ff, pass_valid_in;
   logic signed [VALUE_W-1:0] pass_val_ff, pass_val_in;

   // Insertion step while loading, left shift while draining.
   always_comb begin
      full_in       = full_ff;
      val_in        = val_ff;
      pass_valid_in = 1'b0;
      pass_val_in   = ins_link.value;
      if (shift) begin
         full_in = right_link.valid;
         val_in  = right_link.value;
      end else if (ins_link.valid) begin
         if (!full_ff) begin
            full_in = 1'b1;
            val_in  = ins_link.value;
         end else if (ins_link.value < val_ff) begin
            val_in        = ins_link.value;
            pass_valid_in = 1'b1;
            pass_val_in   = val_ff;
         end else begin
            pass_valid_in = 1'b1;
            pass_val_in   = ins_link.value;
         end
      end
   end

   // Presence bits are control state; the values are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff       <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         full_ff       <= full_in;
         pass_valid_ff <= pass_valid_in;
      end
      val_ff      <= val_in;
      pass_val_ff <= pass_val_in;
   end

   assign pass_link.valid = pass_valid_ff;
   assign pass_link.value = pass_val_ff;
   assign hold_link.valid = full_ff;
   assign hold_link.value = val_ff;

endmodule

### design/ascending_value_sorter_unit.sv
// Top level of the ascending value sorter: cell chain, load/drain control and result register.

// Sorts a list of signed 32-bit values into ascending order with a chain of MAX_COUNT
// compare-and-keep cells. While a list loads, one value is taken every cycle; each new value
// ripples down the chain one cell per cycle, every cell keeping the smaller value. Values past
// the capacity are dropped and flagged with rsp_overflowed on every result of that list. After
// the transfer marked final, the input is stalled through a settling phase while the last
// values reach their cells, then the chain shifts left and delivers one result per cycle
// while the result side does not stall, smallest first, with rsp_end_of_list on the largest.
// The next list loads as soon as the last result has entered the output register.
module ascending_value_sorter_unit
   import asv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_is_final,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_sorted_value,
   output logic                      rsp_end_of_list,
   output logic                      rsp_overflowed
);

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_SETTLE = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] settle_ff, settle_in;
   logic             overflow_ff, overflow_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_end_ff, rsp_end_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic     req_take;
   logic     store_full;
   logic     out_free;
   logic     shift;
   link_type inject_link;
   link_type pass_link [MAX_COUNT];
   link_type hold_link [MAX_COUNT];

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_take   = req_valid && !req_stall;
   assign store_full = (count_ff == CNT_W'(MAX_COUNT));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign inject_link.valid = req_take && !store_full;
   assign inject_link.value = req_value;

   // Cell chain: insertion waves move right, the drain shift moves left.
   for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
      link_type ins_link;
      link_type right_link;
      if (i == 0) begin : g_first
         assign ins_link = inject_link;
      end else begin : g_inner
         assign ins_link = pass_link[i-1];
      end
      if (i == MAX_COUNT - 1) begin : g_last
         assign right_link = '0;
      end else begin : g_mid
         assign right_link = hold_link[i+1];
      end
      asv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .ins_link   (ins_link),
         .right_link (right_link),
         .pass_link  (pass_link[i]),
         .hold_link  (hold_link[i])
      );
   end

   // Load, settle and drain sequencing with the result register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      settle_in    = settle_ff;
      overflow_in  = overflow_ff;
      shift        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (store_full) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_is_final) begin
                  state_in  = ST_SETTLE;
                  settle_in = CNT_W'(MAX_COUNT);
               end
            end
         end
         ST_SETTLE: begin
            settle_in = settle_ff - CNT_W'(1);
            if (settle_ff == CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               shift        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_value_in = hold_link[0].value;
               rsp_end_in   = (count_ff == CNT_W'(1));
               rsp_ovf_in   = overflow_ff;
               count_in     = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in    = ST_LOAD;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         settle_ff    <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         settle_ff    <= settle_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_list  = rsp_end_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

`ifndef SYNTHESIS
   // A value never falls off the far end of the chain.
   a_no_spill: assert property (@(posedge clock) disable iff (reset)
      !pass_link[MAX_COUNT-1].valid)
      else $error("value passed beyond the last cell");

   // The kept-value count never exceeds the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_COUNT))
      else $error("element count above capacity");

   // Every drain shift reads an occupied head cell.
   a_head_full: assert property (@(posedge clock) disable iff (reset)
      shift |-> hold_link[0].valid)
      else $error("drain read an empty head cell");

   // The chain is settled when draining starts: the first cell passes no insertion wave on.
   a_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> !pass_link[0].valid)
      else $error("insertion wave still moving during drain");
`endif

endmodule
